// ===== rtl/adc_voltmeter_seven_segment_assert.svh =====
// Assertion macros, clocked on clk_i and disabled while rst_ni is low
`ifndef ADC_VOLTMETER_SEVEN_SEGMENT_ASSERT_SVH
`define ADC_VOLTMETER_SEVEN_SEGMENT_ASSERT_SVH

// same-cycle implication
`define ADCVM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adcvm assertion failed");

// next-cycle implication
`define ADCVM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("adcvm assertion failed");

`endif

// ===== rtl/adcvm_pkg.sv =====
package adcvm_pkg;

  localparam int SampleW     = 12;
  localparam int MvW         = 12;
  localparam int TenthsW     = 15;
  localparam int TenthsFullW = 15;
  localparam int TenthsFull  = 30000;
  localparam int ProdW       = SampleW + TenthsFullW;
  localparam int RoundW      = TenthsW + 1;
  localparam int RecipW      = 32;
  localparam int Recip10     = 52429;   // 2^19 / 10, rounded up
  localparam int Recip10Sh   = 19;
  localparam int HalfTenth   = 5;
  localparam int SegW        = 8;
  localparam int SegDpW      = 9;
  localparam int DpAdd       = 128;
  localparam int ThouRemW    = 10;
  localparam int HundRemW    = 7;
  localparam int StepThou    = 1000;
  localparam int StepHund    = 100;
  localparam int StepTen     = 10;
  localparam int MvMax       = 2999;
  localparam int ThrReset    = 1500;

  function automatic logic [SegW-1:0] seg_code(input logic [3:0] digit);
    logic [SegW-1:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = 8'hFF;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/adcvm_scale.sv =====
`include "adc_voltmeter_seven_segment_assert.svh"

module adcvm_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [adcvm_pkg::SampleW-1:0] adc_sample_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [adcvm_pkg::MvW-1:0]  mv_o
);
  import adcvm_pkg::*;

  logic               v1_q, v2_q;
  logic               rdy1, rdy2;
  logic [ProdW-1:0]   prod;
  logic [TenthsW-1:0] tenths_d, tenths_q;
  logic [RoundW-1:0]  rnd;
  logic [RecipW-1:0]  quot;
  logic [MvW-1:0]     mv_d, mv_q;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // tenths of a millivolt: sample * 30000 / 4096
  assign prod     = ProdW'(adc_sample_i) * ProdW'(TenthsFull);
  assign tenths_d = prod[SampleW +: TenthsW];

  // round half up: (t + 5) / 10 by reciprocal
  assign rnd  = RoundW'(tenths_q) + RoundW'(HalfTenth);
  assign quot = RecipW'(rnd) * RecipW'(Recip10);
  assign mv_d = quot[Recip10Sh +: MvW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) tenths_q <= tenths_d;
    if (v1_q && rdy2)    mv_q     <= mv_d;
  end

  assign valid_o = v2_q;
  assign mv_o    = mv_q;

  `ADCVM_ASSERT_IMP(a_mv_range, v2_q, mv_q <= MvW'(MvMax))
  `ADCVM_ASSERT_NXT(a_s1_fill, valid_i && rdy1, v1_q)

endmodule

// ===== rtl/adcvm_digit.sv =====
`include "adc_voltmeter_seven_segment_assert.svh"

module adcvm_digit #(
  parameter int InW    = adcvm_pkg::MvW,
  parameter int RemW   = adcvm_pkg::ThouRemW,
  parameter int Step   = adcvm_pkg::StepThou,
  parameter int CarryW = adcvm_pkg::MvW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [InW-1:0]                rem_i,
  input  logic [CarryW-1:0]             carry_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [RemW-1:0]               rem_o,
  output logic [adcvm_pkg::SegW-1:0]    seg_o,
  output logic [CarryW-1:0]             carry_o
);
  import adcvm_pkg::*;

  logic              v_q;
  logic [3:0]        dig;
  logic [InW-1:0]    sub;
  logic [RemW-1:0]   rem_q;
  logic [SegW-1:0]   seg_q;
  logic [CarryW-1:0] carry_q;

  assign ready_o = !v_q || ready_i;

  always_comb begin
    dig = '0;
    sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if (int'(rem_i) >= k * Step) begin
        dig = 4'(k);
        sub = InW'(k * Step);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rem_q   <= RemW'(rem_i - sub);
      seg_q   <= seg_code(dig);
      carry_q <= carry_i;
    end
  end

  assign valid_o = v_q;
  assign rem_o   = rem_q;
  assign seg_o   = seg_q;
  assign carry_o = carry_q;

  `ADCVM_ASSERT_IMP(a_rem_below_step, v_q, int'(rem_q) < Step)

endmodule

// ===== rtl/adcvm_out.sv =====
`include "adc_voltmeter_seven_segment_assert.svh"

module adcvm_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [adcvm_pkg::HundRemW-1:0] rem_i,
  input  logic [adcvm_pkg::MvW-1:0]     mv_i,
  input  logic [adcvm_pkg::SegW-1:0]    seg_th_i,
  input  logic [adcvm_pkg::SegW-1:0]    seg_hu_i,
  input  logic [adcvm_pkg::MvW-1:0]     thr_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [adcvm_pkg::MvW-1:0]     millivolts_o,
  output logic                          alarm_on_o,
  output logic [adcvm_pkg::SegDpW-1:0]  seg_thousands_o,
  output logic [adcvm_pkg::SegW-1:0]    seg_hundreds_o,
  output logic [adcvm_pkg::SegW-1:0]    seg_tens_o,
  output logic [adcvm_pkg::SegW-1:0]    seg_units_o
);
  import adcvm_pkg::*;

  logic                v_q;
  logic [3:0]          tens;
  logic [HundRemW-1:0] sub;
  logic [HundRemW-1:0] units;
  logic [MvW-1:0]      mv_q;
  logic                alarm_q;
  logic [SegDpW-1:0]   seg_th_q;
  logic [SegW-1:0]     seg_hu_q, seg_te_q, seg_un_q;

  assign ready_o = !v_q || out_ready_i;

  always_comb begin
    tens = '0;
    sub  = '0;
    for (int k = 1; k <= 9; k++) begin
      if (int'(rem_i) >= k * StepTen) begin
        tens = 4'(k);
        sub  = HundRemW'(k * StepTen);
      end
    end
  end

  assign units = rem_i - sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mv_q     <= mv_i;
      alarm_q  <= mv_i > thr_i;
      seg_th_q <= SegDpW'(seg_th_i) + SegDpW'(DpAdd);
      seg_hu_q <= seg_hu_i;
      seg_te_q <= seg_code(tens);
      seg_un_q <= seg_code(units[3:0]);
    end
  end

  assign out_valid_o     = v_q;
  assign millivolts_o    = mv_q;
  assign alarm_on_o      = alarm_q;
  assign seg_thousands_o = seg_th_q;
  assign seg_hundreds_o  = seg_hu_q;
  assign seg_tens_o      = seg_te_q;
  assign seg_units_o     = seg_un_q;

  `ADCVM_ASSERT_IMP(a_alarm_match, v_q, alarm_q == (mv_q > thr_i))
  `ADCVM_ASSERT_IMP(a_dp_bit, v_q, seg_th_q[SegDpW-1])

endmodule

// ===== rtl/adc_voltmeter_seven_segment.sv =====
// Channel   Handshake                Payload
// config    cfg_we_i                 cfg_wdata_i (alarm threshold, mV)
// sample    in_valid_i / in_ready_o  adc_sample_i
// result    out_valid_o / out_ready_i millivolts_o, alarm_on_o, seg_*_o
//
// Five register stages: scale multiply, divide-by-ten rounding, thousands,
// hundreds, tens/units with segment encode. One request per cycle is
// sustained while out_ready_i stays high. Each stage holds while the one
// after it is full and stalled; ready is the stage valid chain. Reset clears
// all valid bits and loads the threshold with 1500 mV.
module adc_voltmeter_seven_segment (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [adcvm_pkg::MvW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [adcvm_pkg::SampleW-1:0] adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [adcvm_pkg::MvW-1:0]     millivolts_o,
  output logic                          alarm_on_o,
  output logic [adcvm_pkg::SegDpW-1:0]  seg_thousands_o,
  output logic [adcvm_pkg::SegW-1:0]    seg_hundreds_o,
  output logic [adcvm_pkg::SegW-1:0]    seg_tens_o,
  output logic [adcvm_pkg::SegW-1:0]    seg_units_o
);
  import adcvm_pkg::*;

  logic [MvW-1:0]      thr_q;
  logic                sc_valid, sc_ready;
  logic [MvW-1:0]      sc_mv;
  logic                th_valid, th_ready;
  logic [ThouRemW-1:0] th_rem;
  logic [SegW-1:0]     th_seg;
  logic [MvW-1:0]      th_mv;
  logic                hu_valid, hu_ready;
  logic [HundRemW-1:0] hu_rem;
  logic [SegW-1:0]     hu_seg;
  logic [MvW+SegW-1:0] hu_carry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= MvW'(ThrReset);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  adcvm_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .adc_sample_i (adc_sample_i),
    .valid_o      (sc_valid),
    .ready_i      (sc_ready),
    .mv_o         (sc_mv)
  );

  adcvm_digit #(
    .InW    (MvW),
    .RemW   (ThouRemW),
    .Step   (StepThou),
    .CarryW (MvW)
  ) u_thousands (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .ready_o (sc_ready),
    .rem_i   (sc_mv),
    .carry_i (sc_mv),
    .valid_o (th_valid),
    .ready_i (th_ready),
    .rem_o   (th_rem),
    .seg_o   (th_seg),
    .carry_o (th_mv)
  );

  adcvm_digit #(
    .InW    (ThouRemW),
    .RemW   (HundRemW),
    .Step   (StepHund),
    .CarryW (MvW + SegW)
  ) u_hundreds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (th_valid),
    .ready_o (th_ready),
    .rem_i   (th_rem),
    .carry_i ({th_mv, th_seg}),
    .valid_o (hu_valid),
    .ready_i (hu_ready),
    .rem_o   (hu_rem),
    .seg_o   (hu_seg),
    .carry_o (hu_carry)
  );

  adcvm_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (hu_valid),
    .ready_o         (hu_ready),
    .rem_i           (hu_rem),
    .mv_i            (hu_carry[SegW +: MvW]),
    .seg_th_i        (hu_carry[SegW-1:0]),
    .seg_hu_i        (hu_seg),
    .thr_i           (thr_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .millivolts_o    (millivolts_o),
    .alarm_on_o      (alarm_on_o),
    .seg_thousands_o (seg_thousands_o),
    .seg_hundreds_o  (seg_hundreds_o),
    .seg_tens_o      (seg_tens_o),
    .seg_units_o     (seg_units_o)
  );

endmodule
